// File: design/berenc_pkg.sv
// shared types, widths and constants of the block energy rank encoder
package berenc_pkg;

   // sample and arithmetic widths
   localparam int SAMPLE_BITS = 16;
   localparam int SQ_W        = 2 * SAMPLE_BITS - 1;
   localparam int Q_FRAC_W    = 32;
   localparam int AMP_W       = 16;
   localparam int ROOT_W      = AMP_W + 1;
   localparam int ROOT_IN_W   = 2 * ROOT_W;

   // configuration register
   localparam int             LIMIT_W     = 7;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd16;

   // port field widths
   localparam int IDX_OUT_W  = 6;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 2;

   // defaults for the top level parameters
   localparam int DEF_MAX_SAMPLES = 4096;
   localparam int DEF_MAX_BLOCKS  = 64;

   // arithmetic unit operations
   typedef enum logic {
      ARITH_DIV  = 1'b0,
      ARITH_ROOT = 1'b1
   } arith_op_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
   } arith_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } arith_stat_type;

endpackage

// File: design/berenc_sample_ram.sv
// frame sample memory, one write port and one registered read port
module berenc_sample_ram
   import berenc_pkg::*;
#(
   parameter int DEPTH  = DEF_MAX_SAMPLES,
   parameter int ADDR_W = 12,
   parameter int DATA_W = SAMPLE_BITS
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, data follows in the cycle after rd_en
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/berenc_arith.sv
// shared iterative unit: restoring long division and integer square root
module berenc_arith
   import berenc_pkg::*;
#(
   parameter int NUM_W = 63,
   parameter int DEN_W = 37
) (
   input  logic                 clock,
   input  logic                 reset,
   input  arith_cmd_type        cmd,
   input  logic [NUM_W-1:0]     num,
   input  logic [DEN_W-1:0]     den,
   output arith_stat_type       stat,
   output logic [NUM_W-1:0]     quo,
   output logic [ROOT_W-1:0]    root
);

   localparam int STEP_W = $clog2(NUM_W + 1);
   localparam int RR_W   = ROOT_W + 3;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   arith_op_type         op_ff, op_in;
   logic [STEP_W-1:0]    cnt_ff, cnt_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [ROOT_IN_W-1:0] rad_ff, rad_in;
   logic [RR_W-1:0]      rrem_ff, rrem_in;
   logic [ROOT_W-1:0]    root_ff, root_in;

   logic [DEN_W:0]       rem_sh;
   logic                 div_ge;
   logic [RR_W-1:0]      rrem_sh;
   logic [RR_W-1:0]      trial;
   logic                 root_ge;

   // one division step: shift in a numerator bit, subtract if it fits
   assign rem_sh = {rem_ff, num_ff[NUM_W-1]};
   assign div_ge = rem_sh >= {1'b0, den_ff};

   // one root step: bring down two radicand bits, try root*4+1
   assign rrem_sh = {rrem_ff[RR_W-3:0], rad_ff[ROOT_IN_W-1 -: 2]};
   assign trial   = {{(RR_W-ROOT_W-2){1'b0}}, root_ff, 2'b01};
   assign root_ge = rrem_sh >= trial;

   // sequencing
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      rad_in  = rad_ff;
      rrem_in = rrem_ff;
      root_in = root_ff;
      if (busy_ff) begin
         unique case (op_ff)
            ARITH_DIV: begin
               num_in = {num_ff[NUM_W-2:0], div_ge};
               rem_in = div_ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
            end
            ARITH_ROOT: begin
               rad_in  = {rad_ff[ROOT_IN_W-3:0], 2'b00};
               rrem_in = root_ge ? (rrem_sh - trial) : rrem_sh;
               root_in = {root_ff[ROOT_W-2:0], root_ge};
            end
            default: begin
               num_in = num_ff;
            end
         endcase
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         rad_in  = num[ROOT_IN_W-1:0];
         rrem_in = '0;
         root_in = '0;
         cnt_in  = (cmd.op == ARITH_DIV) ? STEP_W'(NUM_W) : STEP_W'(ROOT_W);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      rad_ff  <= rad_in;
      rrem_ff <= rrem_in;
      root_ff <= root_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quo       = num_ff;
   assign root      = root_ff;

   // a new operation is only issued to an idle unit
   assert property (@(posedge clock) disable iff (reset) cmd.start |-> !busy_ff)
      else $error("arith unit started while busy");

endmodule

// File: design/block_energy_rank_encoder_unit.sv
// top level of the block energy rank encoder: frame load, block pass, ranking, output
//
//  channel | direction | transfer carries
//  req_*   | in        | one sample (tdata), end of frame (tlast)
//  rsp_*   | out       | block index and amplitude (tdata), last result (tlast), flags (tuser)
//  csr_*   | in        | block limit, written while csr_write_en is high
//
// Samples load at one per cycle. After the frame's final sample the block takes no sample
// until its last result is loaded: one divide for the block size, then per block its length
// in sample reads and one divide, then per result a scan over the mean square memory, one
// divide and a 17 step root, all on the one shared arithmetic unit. Reset is synchronous and
// needs no clearing pass. A stalled result is held in the output register while the next
// frame's samples are taken.
module block_energy_rank_encoder_unit
   import berenc_pkg::*;
#(
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
   parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] sample
   input  logic                  req_tlast,   // last sample
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [5:0] block index, [21:6] amplitude, rest 0
   output logic                  rsp_tlast,   // last result
   output logic [RSP_USER_W-1:0] rsp_tuser,   // [0] none kept, [1] overflowed
   input  logic                  csr_write_en,
   input  logic [LIMIT_W-1:0]    csr_write_data
);

   localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
   localparam int SADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int BIDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int BCNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int SUM_W   = SQ_W + CNT_W;
   localparam int MS_W    = SQ_W;
   localparam int E_W     = MS_W + BCNT_W;
   localparam int NUM_W   = (SUM_W > MS_W + Q_FRAC_W) ? SUM_W : MS_W + Q_FRAC_W;
   localparam int DEN_W   = (E_W > CNT_W) ? E_W : CNT_W;
   localparam int MIX_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   typedef enum logic [12:0] {
      S_LOAD       = 13'b0000000000001,
      S_SETUP      = 13'b0000000000010,
      S_BSIZE_WAIT = 13'b0000000000100,
      S_BLK_READ   = 13'b0000000001000,
      S_BLK_DRAIN  = 13'b0000000010000,
      S_MS_WAIT    = 13'b0000000100000,
      S_SCAN_START = 13'b0000001000000,
      S_SCAN       = 13'b0000010000000,
      S_SCAN_DRAIN = 13'b0000100000000,
      S_RATIO_GO   = 13'b0001000000000,
      S_RATIO_WAIT = 13'b0010000000000,
      S_ROOT_WAIT  = 13'b0100000000000,
      S_EMIT       = 13'b1000000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [LIMIT_W-1:0]   limit_ff;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 ovf_ff, ovf_in;
   logic [BCNT_W-1:0]    blocks_ff, blocks_in;
   logic [CNT_W-1:0]     bsize_ff, bsize_in;
   logic [BCNT_W-1:0]    blk_ff, blk_in;
   logic [CNT_W-1:0]     start_ff, start_in;
   logic [CNT_W-1:0]     end_ff, end_in;
   logic [CNT_W-1:0]     rd_addr_ff, rd_addr_in;
   logic                 rd_pend_ff;
   logic                 sq_vld_ff;
   logic [SQ_W-1:0]      sq_ff;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [E_W-1:0]       energy_ff, energy_in;
   logic [BCNT_W-1:0]    keep_ff, keep_in;
   logic [BCNT_W-1:0]    emit_cnt_ff, emit_cnt_in;
   logic [BCNT_W-1:0]    scan_ptr_ff, scan_ptr_in;
   logic                 scan_vld_ff;
   logic [BIDX_W-1:0]    scan_tag_ff;
   logic [MS_W-1:0]      ms_rd_ff;
   logic [MS_W-1:0]      best_ms_ff, best_ms_in;
   logic [BIDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [MAX_BLOCKS-1:0] used_ff, used_in;
   logic [AMP_W-1:0]     amp_ff, amp_in;
   logic                 none_ff, none_in;

   logic                 rsp_vld_ff, rsp_vld_in;
   logic [IDX_OUT_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [AMP_W-1:0]     rsp_amp_ff, rsp_amp_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_none_ff, rsp_none_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   logic [MS_W-1:0]      ms_mem [MAX_BLOCKS];

   logic                 req_xfer;
   logic                 ram_wr_en;
   logic                 ram_rd_en;
   logic [SAMPLE_BITS-1:0] ram_rd_data;
   logic [LIMIT_W-1:0]   lim_eff;
   logic [MIX_W-1:0]     lim_mix;
   logic [MIX_W-1:0]     n_mix;
   logic [MS_W-1:0]      ms_val;
   logic                 ms_wr_en;
   logic                 ms_rd_en;
   logic                 last_pick;

   arith_cmd_type        a_cmd;
   arith_stat_type       a_stat;
   logic [NUM_W-1:0]     a_num;
   logic [DEN_W-1:0]     a_den;
   logic [NUM_W-1:0]     a_quo;
   logic [ROOT_W-1:0]    a_root;

   assign req_tready = (state_ff == S_LOAD);
   assign req_xfer   = req_tvalid && req_tready;
   assign ram_wr_en  = req_xfer && (cnt_ff < CNT_W'(MAX_SAMPLES));
   assign ram_rd_en  = (state_ff == S_BLK_READ);
   assign ms_rd_en   = (state_ff == S_SCAN);

   // block limit clamped to 1..MAX_BLOCKS
   always_comb begin
      lim_eff = limit_ff;
      if (limit_ff == '0) begin
         lim_eff = LIMIT_W'(1);
      end else if (limit_ff > LIMIT_W'(MAX_BLOCKS)) begin
         lim_eff = LIMIT_W'(MAX_BLOCKS);
      end
   end
   assign lim_mix = MIX_W'(lim_eff);
   assign n_mix   = MIX_W'(cnt_ff);

   // mean square of the finished block, a nonzero sum keeps at least 1
   assign ms_val = ((sum_ff != '0) && (a_quo[MS_W-1:0] == '0)) ? MS_W'(1) : a_quo[MS_W-1:0];
   assign ms_wr_en = (state_ff == S_MS_WAIT) && a_stat.done;

   assign last_pick = none_ff || (BCNT_W'(emit_cnt_ff + 1'b1) == keep_ff);

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_write_en) begin
         limit_ff <= csr_write_data;
      end
   end

   // frame sample memory
   berenc_sample_ram #(
      .DEPTH  (MAX_SAMPLES),
      .ADDR_W (SADDR_W),
      .DATA_W (SAMPLE_BITS)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cnt_ff[SADDR_W-1:0]),
      .wr_data (req_tdata[SAMPLE_BITS-1:0]),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_addr_ff[SADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // shared divide and root unit
   berenc_arith #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (a_cmd),
      .num   (a_num),
      .den   (a_den),
      .stat  (a_stat),
      .quo   (a_quo),
      .root  (a_root)
   );

   // per block mean square memory
   always_ff @(posedge clock) begin
      if (ms_wr_en) begin
         ms_mem[blk_ff[BIDX_W-1:0]] <= ms_val;
      end
      if (ms_rd_en) begin
         ms_rd_ff <= ms_mem[scan_ptr_ff[BIDX_W-1:0]];
      end
   end

   // read, square and accumulate pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff  <= 1'b0;
         sq_vld_ff   <= 1'b0;
         scan_vld_ff <= 1'b0;
      end else begin
         rd_pend_ff  <= ram_rd_en;
         sq_vld_ff   <= rd_pend_ff;
         scan_vld_ff <= ms_rd_en;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff       <= SQ_W'($signed(ram_rd_data) * $signed(ram_rd_data));
      scan_tag_ff <= scan_ptr_ff[BIDX_W-1:0];
   end

   // control sequencer
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      ovf_in      = ovf_ff;
      blocks_in   = blocks_ff;
      bsize_in    = bsize_ff;
      blk_in      = blk_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      rd_addr_in  = rd_addr_ff;
      sum_in      = sum_ff;
      energy_in   = energy_ff;
      keep_in     = keep_ff;
      emit_cnt_in = emit_cnt_ff;
      scan_ptr_in = scan_ptr_ff;
      best_ms_in  = best_ms_ff;
      best_idx_in = best_idx_ff;
      used_in     = used_ff;
      amp_in      = amp_ff;
      none_in     = none_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_idx_in  = rsp_idx_ff;
      rsp_amp_in  = rsp_amp_ff;
      rsp_last_in = rsp_last_ff;
      rsp_none_in = rsp_none_ff;
      rsp_ovf_in  = rsp_ovf_ff;
      a_cmd.start = 1'b0;
      a_cmd.op    = ARITH_DIV;
      a_num       = NUM_W'(sum_ff);
      a_den       = DEN_W'(end_ff - start_ff);

      // square accumulation
      if (sq_vld_ff) begin
         sum_in = sum_ff + SUM_W'(sq_ff);
      end

      // running maximum, strict compare keeps the lower index on ties
      if (scan_vld_ff && !used_ff[scan_tag_ff] && (ms_rd_ff > best_ms_ff)) begin
         best_ms_in  = ms_rd_ff;
         best_idx_in = scan_tag_ff;
      end

      unique case (state_ff)
         S_LOAD: begin
            if (req_xfer) begin
               if (ram_wr_en) begin
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = S_SETUP;
               end
            end
         end
         S_SETUP: begin
            keep_in   = '0;
            energy_in = '0;
            blocks_in = (lim_mix < n_mix) ? BCNT_W'(lim_eff) : BCNT_W'(cnt_ff);
            if (cnt_ff == '0) begin
               state_in = S_SCAN_START;
            end else begin
               a_cmd.start = 1'b1;
               a_cmd.op    = ARITH_DIV;
               a_num       = NUM_W'(cnt_ff);
               a_den       = DEN_W'(blocks_in);
               state_in    = S_BSIZE_WAIT;
            end
         end
         S_BSIZE_WAIT: begin
            if (a_stat.done) begin
               bsize_in   = a_quo[CNT_W-1:0];
               blk_in     = '0;
               start_in   = '0;
               rd_addr_in = '0;
               end_in     = (blocks_ff == BCNT_W'(1)) ? cnt_ff : a_quo[CNT_W-1:0];
               sum_in     = '0;
               used_in    = '0;
               state_in   = S_BLK_READ;
            end
         end
         S_BLK_READ: begin
            rd_addr_in = rd_addr_ff + 1'b1;
            if (CNT_W'(rd_addr_ff + 1'b1) == end_ff) begin
               state_in = S_BLK_DRAIN;
            end
         end
         S_BLK_DRAIN: begin
            if (!rd_pend_ff && !sq_vld_ff) begin
               a_cmd.start = 1'b1;
               a_cmd.op    = ARITH_DIV;
               state_in    = S_MS_WAIT;
            end
         end
         S_MS_WAIT: begin
            if (a_stat.done) begin
               energy_in = energy_ff + E_W'(ms_val);
               if (ms_val != '0) begin
                  keep_in = keep_ff + 1'b1;
               end
               if (BCNT_W'(blk_ff + 1'b1) == blocks_ff) begin
                  emit_cnt_in = '0;
                  state_in    = S_SCAN_START;
               end else begin
                  blk_in   = blk_ff + 1'b1;
                  start_in = end_ff;
                  end_in   = (BCNT_W'(blk_ff + 2'd2) == blocks_ff) ? cnt_ff : end_ff + bsize_ff;
                  sum_in   = '0;
                  state_in = S_BLK_READ;
               end
            end
         end
         S_SCAN_START: begin
            if (keep_ff == '0) begin
               none_in  = 1'b1;
               state_in = S_EMIT;
            end else begin
               scan_ptr_in = '0;
               best_ms_in  = '0;
               best_idx_in = '0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            if (BCNT_W'(scan_ptr_ff + 1'b1) == blocks_ff) begin
               state_in = S_SCAN_DRAIN;
            end else begin
               scan_ptr_in = scan_ptr_ff + 1'b1;
            end
         end
         S_SCAN_DRAIN: begin
            state_in = S_RATIO_GO;
         end
         S_RATIO_GO: begin
            a_cmd.start = 1'b1;
            a_cmd.op    = ARITH_DIV;
            a_num       = NUM_W'({best_ms_ff, {Q_FRAC_W{1'b0}}});
            a_den       = DEN_W'(energy_ff);
            state_in    = S_RATIO_WAIT;
         end
         S_RATIO_WAIT: begin
            if (a_stat.done) begin
               a_cmd.start = 1'b1;
               a_cmd.op    = ARITH_ROOT;
               a_num       = NUM_W'(a_quo[ROOT_IN_W-1:0]);
               state_in    = S_ROOT_WAIT;
            end
         end
         S_ROOT_WAIT: begin
            if (a_stat.done) begin
               amp_in   = a_root[ROOT_W-1] ? {AMP_W{1'b1}} : a_root[AMP_W-1:0];
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_idx_in  = none_ff ? '0 : IDX_OUT_W'(best_idx_ff);
               rsp_amp_in  = none_ff ? '0 : amp_ff;
               rsp_last_in = last_pick;
               rsp_none_in = none_ff;
               rsp_ovf_in  = ovf_ff;
               used_in[best_idx_ff] = 1'b1;
               emit_cnt_in = emit_cnt_ff + 1'b1;
               if (last_pick) begin
                  cnt_in    = '0;
                  ovf_in    = 1'b0;
                  none_in   = 1'b0;
                  energy_in = '0;
                  state_in  = S_LOAD;
               end else begin
                  state_in = S_SCAN_START;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         cnt_ff      <= '0;
         ovf_ff      <= 1'b0;
         energy_ff   <= '0;
         keep_ff     <= '0;
         emit_cnt_ff <= '0;
         none_ff     <= 1'b0;
         used_ff     <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         ovf_ff      <= ovf_in;
         energy_ff   <= energy_in;
         keep_ff     <= keep_in;
         emit_cnt_ff <= emit_cnt_in;
         none_ff     <= none_in;
         used_ff     <= used_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      blocks_ff   <= blocks_in;
      bsize_ff    <= bsize_in;
      blk_ff      <= blk_in;
      start_ff    <= start_in;
      end_ff      <= end_in;
      rd_addr_ff  <= rd_addr_in;
      sum_ff      <= sum_in;
      scan_ptr_ff <= scan_ptr_in;
      best_ms_ff  <= best_ms_in;
      best_idx_ff <= best_idx_in;
      amp_ff      <= amp_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_amp_ff  <= rsp_amp_in;
      rsp_last_ff <= rsp_last_in;
      rsp_none_ff <= rsp_none_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   // result channel
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-IDX_OUT_W-AMP_W){1'b0}}, rsp_amp_ff, rsp_idx_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_ovf_ff, rsp_none_ff};

   // stored sample count never passes the memory depth
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count beyond capacity");

   // a ranked pick always has energy
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RATIO_GO) |-> (best_ms_ff != '0))
      else $error("zero energy block picked for output");

   // results of a frame never outnumber its kept blocks
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_EMIT) && !none_ff) |-> (emit_cnt_ff < keep_ff))
      else $error("more results than kept blocks");

endmodule
